// File: design/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg: shared types for the LRU page replacement block
// Item payloads for both channels and the control bundle sent to each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int PAGE_IN_W = 16;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // input item: one page reference
    typedef struct packed {
        logic [PAGE_IN_W-1:0] page_number;
        logic                 last_in_string;
    } lru_in_t;

    // result item
    typedef struct packed {
        logic                 hit;
        logic [SLOT_W-1:0]    frame_slot;
        logic                 evicted_valid;
        logic [PAGE_IN_W-1:0] evicted_page;
        logic [COUNT_W-1:0]   fault_count;
        logic                 string_done;
    } lru_out_t;

    // control broadcast to every frame cell
    typedef struct packed {
        logic accept;   // an item is taken this cycle
        logic clear;    // return to reset state after this item
        logic hit;      // the page is resident in some frame
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/lrupr_cell.sv
// ----------------------------------------------------------------------------
// lrupr_cell: one frame of the LRU chain
// Holds page, valid mark and recency rank; passes the found flag down the
// chain and ages its rank when another frame becomes most recent.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_cell #(
    parameter int INDEX       = 0,
    parameter int FRAME_COUNT = 4,
    parameter int PAGE_BITS   = 16,
    parameter int RANK_W      = 2
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [PAGE_BITS-1:0]  key,
    input  wire logic                  found_in,
    output logic                       found_out,
    input  wire lrupr_pkg::cell_ctrl_t ctrl,
    input  wire logic [RANK_W-1:0]     sel_rank,
    output logic                       target,
    output logic [RANK_W-1:0]          rank_q,
    output logic [PAGE_BITS-1:0]       page_q,
    output logic                       valid_q
);
    import lrupr_pkg::*;

    localparam logic [RANK_W-1:0] RANK_TOP   = RANK_W'(FRAME_COUNT - 1);
    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(INDEX);

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 valid_reg, valid_next;
    logic [RANK_W-1:0]    rank_reg, rank_next;
    logic                 match;

    // compare and pass the found flag on; first match in chain order wins
    assign match     = valid_reg && (page_reg == key);
    assign found_out = found_in || match;
    assign target    = ctrl.hit ? (match && !found_in) : (rank_reg == '0);

    assign rank_q  = rank_reg;
    assign page_q  = page_reg;
    assign valid_q = valid_reg;

    // refill on miss, promote the target, age the more recent frames
    always_comb begin
        page_next  = page_reg;
        valid_next = valid_reg;
        rank_next  = rank_reg;
        if (ctrl.accept) begin
            if (ctrl.clear) begin
                valid_next = 1'b0;
                rank_next  = RANK_RESET;
                page_next  = '0;
            end else if (target) begin
                rank_next = RANK_TOP;
                if (!ctrl.hit) begin
                    page_next  = key;
                    valid_next = 1'b1;
                end
            end else if (rank_reg > sel_rank) begin
                rank_next = rank_reg - RANK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rank_reg  <= RANK_RESET;
        end else begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    // page payload holds no reset; it is gated by the valid mark
    always_ff @(posedge aclk) begin
        page_reg <= page_next;
    end

endmodule

`default_nettype wire

// File: design/lru_page_replacement.sv
// Output: each accepted item's result is loaded into the output register.
// Throughput: one item per cycle unless output stalls; the frame chain compares,
//   selects and updates ranks in the accepting cycle, so the next item sees the new state.
// Reset: synchronous active-low aresetn empties all frames, sets ranks to the
//   frame index and clears the fault counter; an item marked last does the same.
// ----------------------------------------------------------------------------
// lru_page_replacement: fully associative LRU frame set
// Chain of frame cells with a shared fault counter and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement #(
    parameter int FRAME_COUNT = 4,
    parameter int PAGE_BITS   = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lrupr_pkg::lru_in_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output lrupr_pkg::lru_out_t     m_data
);
    import lrupr_pkg::*;

    localparam int RANK_W = $clog2(FRAME_COUNT);

    logic                 accept;
    logic [PAGE_BITS-1:0] key;
    logic [FRAME_COUNT:0] found;
    logic [FRAME_COUNT-1:0] target;
    logic [FRAME_COUNT-1:0] cell_valid;
    logic [RANK_W-1:0]    cell_rank [FRAME_COUNT];
    logic [PAGE_BITS-1:0] cell_page [FRAME_COUNT];
    cell_ctrl_t           ctrl;
    logic                 hit;
    logic [RANK_W-1:0]    sel_rank;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page_full;
    logic [PAGE_IN_W-1:0] ev_page;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next, cnt_inc;
    lru_out_t             out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // take an item whenever the output register is free or draining
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // form the compare key from the page field
    generate
        if (PAGE_BITS >= PAGE_IN_W) begin : g_key_wide
            assign key = PAGE_BITS'(s_data.page_number);
        end else begin : g_key_narrow
            assign key = s_data.page_number[PAGE_BITS-1:0];
        end
    endgenerate

    assign found[0]   = 1'b0;
    assign hit        = found[FRAME_COUNT];
    assign ctrl.accept = accept;
    assign ctrl.clear  = s_data.last_in_string;
    assign ctrl.hit    = hit;

    // frame chain
    generate
        for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
            lrupr_cell #(
                .INDEX       (i),
                .FRAME_COUNT (FRAME_COUNT),
                .PAGE_BITS   (PAGE_BITS),
                .RANK_W      (RANK_W)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .key       (key),
                .found_in  (found[i]),
                .found_out (found[i+1]),
                .ctrl      (ctrl),
                .sel_rank  (sel_rank),
                .target    (target[i]),
                .rank_q    (cell_rank[i]),
                .page_q    (cell_page[i]),
                .valid_q   (cell_valid[i])
            );
        end
    endgenerate

    // gather rank, slot and displaced page of the one target frame
    always_comb begin
        sel_rank     = '0;
        slot         = '0;
        ev_valid     = 1'b0;
        ev_page_full = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (target[i]) begin
                sel_rank |= cell_rank[i];
                slot     |= SLOT_W'(i);
                if (!hit && cell_valid[i]) begin
                    ev_valid     = 1'b1;
                    ev_page_full |= cell_page[i];
                end
            end
        end
    end

    generate
        if (PAGE_BITS >= PAGE_IN_W) begin : g_ev_wide
            assign ev_page = ev_page_full[PAGE_IN_W-1:0];
        end else begin : g_ev_narrow
            assign ev_page = PAGE_IN_W'(ev_page_full);
        end
    endgenerate

    // saturating fault counter; drop to zero after the last item
    assign cnt_inc = (!hit && (cnt_reg != COUNT_MAX)) ? cnt_reg + COUNT_W'(1) : cnt_reg;

    always_comb begin
        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = s_data.last_in_string ? '0 : cnt_inc;
        end
    end

    // load the result register, hold it while stalled
    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            out_valid_next         = 1'b1;
            out_next.hit           = hit;
            out_next.frame_slot    = slot;
            out_next.evicted_valid = ev_valid;
            out_next.evicted_page  = ev_page;
            out_next.fault_count   = cnt_inc;
            out_next.string_done   = s_data.last_in_string;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    // exactly one frame is chosen for every item
    a_one_target: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> $onehot(target))
        else $error("target frame not unique");

    // a hit never reports a displaced page
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> !m_data.evicted_valid && (m_data.evicted_page == '0))
        else $error("hit with eviction");

    // the last item of a string leaves all frames empty and the counter clear
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.last_in_string |=> (cnt_reg == '0) && (cell_valid == '0))
        else $error("state not cleared after last item");

    // a fault result carries a count that is never zero
    a_fault_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> (m_data.fault_count != '0))
        else $error("fault without count");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the LRU page replacement block
// Feeds page references through a queue-driven driver, predicts every result
// with an in-bench LRU frame model and compares each result field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import lrupr_pkg::*;

    localparam int FRAMES      = 4;
    localparam int PAGE_WIDTH  = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 200;
    localparam int RANDOM_REFS = 880;
    localparam int TAIL_REFS   = 40;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    lru_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    lru_out_t m_data;

    // predicted frame set
    logic [PAGE_WIDTH-1:0] resident_page [FRAMES];
    logic                  resident_valid[FRAMES];
    int                    age_rank      [FRAMES];
    logic [COUNT_W-1:0]    miss_total;

    lru_in_t  pending_refs[$];
    lru_out_t expected_results[$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  stall_cycles = 0;
    bit  in_taken     = 1'b0;
    bit  bursts_off   = 1'b0;
    int  src_gap      = 0;
    int  sink_gap     = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;

    lru_page_replacement #(
        .FRAME_COUNT(FRAMES),
        .PAGE_BITS  (PAGE_WIDTH)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // empty all frames, ranks follow frame index
    task automatic frames_clear();
        for (int i = 0; i < FRAMES; i++) begin
            resident_page[i]  = '0;
            resident_valid[i] = 1'b0;
            age_rank[i]       = i;
        end
        miss_total = '0;
    endtask

    // look up one reference, update the frame set and build its result
    task automatic lru_predict(input lru_in_t access, output lru_out_t res);
        int   slot;
        int   old_rank;
        bit   found;
        found = 1'b0;
        slot  = 0;
        res   = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (!found && resident_valid[i] && resident_page[i] == access.page_number) begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (!found) begin
            for (int i = FRAMES - 1; i >= 0; i--) begin
                if (age_rank[i] == 0) slot = i;
            end
            if (resident_valid[slot]) begin
                res.evicted_valid = 1'b1;
                res.evicted_page  = resident_page[slot];
            end
            resident_page[slot]  = access.page_number;
            resident_valid[slot] = 1'b1;
            if (miss_total != COUNT_MAX) miss_total = miss_total + 1'b1;
        end
        old_rank = age_rank[slot];
        for (int i = 0; i < FRAMES; i++) begin
            if (age_rank[i] > old_rank) age_rank[i] = age_rank[i] - 1;
        end
        age_rank[slot]  = FRAMES - 1;
        res.hit         = found;
        res.frame_slot  = slot[SLOT_W-1:0];
        res.fault_count = miss_total;
        res.string_done = access.last_in_string;
        if (access.last_in_string) frames_clear();
    endtask

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t result %0d: %s got %0h want %0h",
                 $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want) note_mismatch(what, got, want);
    endtask

    task automatic queue_ref(input logic [PAGE_WIDTH-1:0] page, input bit last);
        lru_in_t item;
        item.page_number    = page;
        item.last_in_string = last;
        pending_refs.push_back(item);
    endtask

    // let every queued item go through and every result come back
    task automatic drain();
        while (pending_refs.size() != 0 || expected_results.size() != 0) @(posedge aclk);
    endtask

    // check results, predict accepted items, watch for a hang
    always @(posedge aclk) begin
        lru_out_t want;
        lru_out_t fresh;
        bit       moved;
        if (aresetn) begin
            moved = 1'b0;
            if (m_valid && m_ready) begin
                moved = 1'b1;
                results_seen++;
                if (expected_results.size() == 0) begin
                    note_mismatch("result with nothing pending", m_data.fault_count, 0);
                end else begin
                    want = expected_results.pop_front();
                    check_field("hit",           m_data.hit,           want.hit);
                    check_field("frame_slot",    m_data.frame_slot,    want.frame_slot);
                    check_field("evicted_valid", m_data.evicted_valid, want.evicted_valid);
                    check_field("evicted_page",  m_data.evicted_page,  want.evicted_page);
                    check_field("fault_count",   m_data.fault_count,   want.fault_count);
                    check_field("string_done",   m_data.string_done,   want.string_done);
                end
            end
            in_taken = s_valid && s_ready;
            if (in_taken) begin
                moved = 1'b1;
                lru_predict(s_data, fresh);
                expected_results.push_back(fresh);
            end
            if (moved) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // drive the next item once the current one is gone, with random gaps
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || in_taken)) begin
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (!bursts_off && $urandom_range(0, 15) == 0) begin
                src_gap = $urandom_range(1, 17) - 1;
                s_valid <= 1'b0;
            end else if (pending_refs.size() != 0) begin
                s_data  <= pending_refs.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side: random stalls and one long hold-off to back up the input
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (!bursts_off && $urandom_range(0, 15) == 0) begin
            sink_gap = $urandom_range(1, 17) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        logic [PAGE_WIDTH-1:0] pool[8];
        int pool_len;
        int str_len;
        int queued;
        frames_clear();
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty frames, page zero, extremes, evictions, string ends
        queue_ref(16'h0000, 1'b0);   // page zero on empty frames misses
        queue_ref(16'h0000, 1'b0);   // now resident
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h1234, 1'b0);
        queue_ref(16'h00FF, 1'b0);   // all frames filled
        queue_ref(16'h0001, 1'b0);   // evicts least recent page zero
        queue_ref(16'hFFFF, 1'b0);
        queue_ref(16'h8000, 1'b0);
        queue_ref(16'hAAAA, 1'b0);
        queue_ref(16'h5555, 1'b0);
        queue_ref(16'hAAAA, 1'b0);
        queue_ref(16'h8000, 1'b1);   // end string on a hit
        queue_ref(16'h8000, 1'b0);   // cleared, misses again
        queue_ref(16'h7FFF, 1'b1);   // end string on a miss
        queue_ref(16'h0000, 1'b1);   // single-item string
        queue_ref(16'hFFFF, 1'b1);
        queue_ref(16'h0003, 1'b0);
        queue_ref(16'h0003, 1'b0);
        queue_ref(16'h0002, 1'b0);
        queue_ref(16'h0001, 1'b0);
        queue_ref(16'h0003, 1'b0);
        queue_ref(16'h0004, 1'b0);
        queue_ref(16'h0005, 1'b0);
        queue_ref(16'h0002, 1'b1);
        drain();

        // random strings over small page pools, with stray pages mixed in
        queued = 0;
        while (queued < RANDOM_REFS) begin
            pool_len = $urandom_range(2, 8);
            for (int i = 0; i < pool_len; i++) begin
                if ($urandom_range(0, 3) == 0) pool[i] = PAGE_WIDTH'($urandom_range(0, 7));
                else pool[i] = PAGE_WIDTH'($urandom_range(0, 65535));
            end
            str_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 60);
            for (int k = 0; k < str_len; k++) begin
                if ($urandom_range(0, 6) == 0)
                    queue_ref(PAGE_WIDTH'($urandom_range(0, 65535)), k == str_len - 1);
                else
                    queue_ref(pool[$urandom_range(0, pool_len - 1)], k == str_len - 1);
                queued++;
            end
        end
        drain();

        // no idling from here: a run of misses over five pages, then string ends
        bursts_off = 1'b1;
        src_gap    = 0;
        sink_gap   = 0;
        for (int k = 0; k < TAIL_REFS; k++) queue_ref(16'hF000 + PAGE_WIDTH'(k % 5), 1'b0);
        queue_ref(16'h0FFF, 1'b1);
        queue_ref(16'hF000, 1'b0);
        queue_ref(16'hF000, 1'b1);
        drain();

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lrupr_pkg.sv
design/lrupr_cell.sv
design/lru_page_replacement.sv
verif/tb_top.sv
